>>> rtl/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg: shared definitions for the scheduled hysteresis thermostat
// Field widths, register map codes and reset values.
// ----------------------------------------------------------------------------
package sht_pkg;

    localparam int TEMP_W  = 12;
    localparam int BAND_W  = 10;
    localparam int TIME_W  = 17;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [TIME_W-1:0]        tod_t;
    typedef logic [BAND_W-1:0]        band_t;

    // register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_HIGH_SETPOINT = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOW_SETPOINT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HYST_BAND     = 3'd2;
    localparam logic [IDX_W-1:0] REG_WINDOW_START  = 3'd3;
    localparam logic [IDX_W-1:0] REG_WINDOW_STOP   = 3'd4;

    // item kinds carried in tuser
    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_OVERRIDE = 1'b1;

    localparam temp_t RST_HIGH_SETPOINT = 12'sd336;
    localparam temp_t RST_LOW_SETPOINT  = 12'sd256;
    localparam band_t RST_HYST_BAND     = 10'd16;
    localparam tod_t  RST_WINDOW_START  = 17'd79200;
    localparam tod_t  RST_WINDOW_STOP   = 17'd32400;

endpackage

>>> rtl/scheduled_hysteresis_thermostat.sv
// ----------------------------------------------------------------------------
// scheduled_hysteresis_thermostat: bang-bang heater control with a daily
// high-setpoint window, manual override and hysteresis band.
// ----------------------------------------------------------------------------
// Datapath: an accepted input beat goes through the input register, then the
// result register, which holds its result beat.
// Throughput: one beat per cycle while m_tready keeps the output moving; the flag
// update between the two registers is the only dependency from one item to the next.
// Reset: asynchronous, active low; flags cleared, registers to defaults.
module scheduled_hysteresis_thermostat
    import sht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [16:0] time_of_day, [28:17] measured_temperature,
    // [40:29] override_setpoint, [47:41] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] operation
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] heater_on, [12:1] target_temperature, [13] in_window,
    // [14] override_active, [15] zero
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // configuration
    temp_t high_sp_reg;
    temp_t low_sp_reg;
    band_t band_reg;
    tod_t  win_start_reg;
    tod_t  win_stop_reg;

    logic             cfg_wr;
    logic [IDX_W-1:0] cfg_idx;

    // input stage
    logic  in_valid_reg;
    logic  in_op_reg;
    tod_t  in_tod_reg;
    temp_t in_temp_reg;
    temp_t in_ovr_reg;

    // control state
    logic  heater_reg,  heater_next;
    logic  window_reg,  window_next;
    logic  ovr_reg,     ovr_next;
    temp_t manual_reg,  manual_next;

    // result stage
    logic  out_valid_reg;
    logic  out_heater_reg;
    temp_t out_target_reg;
    logic  out_window_reg;
    logic  out_ovr_reg;

    logic  advance;
    logic  win;
    temp_t target;
    logic signed [TEMP_W+1:0] half;
    logic signed [TEMP_W+1:0] upper;
    logic signed [TEMP_W+1:0] lower;
    logic signed [TEMP_W+1:0] temp_ext;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_sp_reg   <= RST_HIGH_SETPOINT;
            low_sp_reg    <= RST_LOW_SETPOINT;
            band_reg      <= RST_HYST_BAND;
            win_start_reg <= RST_WINDOW_START;
            win_stop_reg  <= RST_WINDOW_STOP;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_HIGH_SETPOINT: high_sp_reg   <= pwdata[TEMP_W-1:0];
                REG_LOW_SETPOINT:  low_sp_reg    <= pwdata[TEMP_W-1:0];
                REG_HYST_BAND:     band_reg      <= pwdata[BAND_W-1:0];
                REG_WINDOW_START:  win_start_reg <= pwdata[TIME_W-1:0];
                REG_WINDOW_STOP:   win_stop_reg  <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_HIGH_SETPOINT: prdata = {{(DATA_W-TEMP_W){1'b0}}, high_sp_reg};
            REG_LOW_SETPOINT:  prdata = {{(DATA_W-TEMP_W){1'b0}}, low_sp_reg};
            REG_HYST_BAND:     prdata = {{(DATA_W-BAND_W){1'b0}}, band_reg};
            REG_WINDOW_START:  prdata = {{(DATA_W-TIME_W){1'b0}}, win_start_reg};
            REG_WINDOW_STOP:   prdata = {{(DATA_W-TIME_W){1'b0}}, win_stop_reg};
            default:           prdata = '0;
        endcase
    end

    // Input stage moves on whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_tod_reg  <= s_tdata[TIME_W-1:0];
            in_temp_reg <= s_tdata[TIME_W+TEMP_W-1:TIME_W];
            in_ovr_reg  <= s_tdata[TIME_W+2*TEMP_W-1:TIME_W+TEMP_W];
        end
    end

    // Window test; a wrapped window spans midnight, an empty one never hits.
    always_comb
    begin
        if (win_stop_reg > win_start_reg)
            win = (in_tod_reg > win_start_reg) && (in_tod_reg < win_stop_reg);
        else if (win_stop_reg < win_start_reg)
            win = (in_tod_reg > win_start_reg) || (in_tod_reg < win_stop_reg);
        else
            win = 1'b0;
    end

    always_comb
    begin
        heater_next = heater_reg;
        window_next = window_reg;
        ovr_next    = ovr_reg;
        manual_next = manual_reg;
        target      = manual_reg;
        half        = $signed({{(TEMP_W+3-BAND_W){1'b0}}, band_reg[BAND_W-1:1]});
        temp_ext    = {{2{in_temp_reg[TEMP_W-1]}}, in_temp_reg};
        upper       = '0;
        lower       = '0;
        if (in_op_reg == OP_OVERRIDE)
        begin
            manual_next = in_ovr_reg;
            ovr_next    = 1'b1;
            target      = in_ovr_reg;
        end
        else
        begin
            // a change of window drops any override
            if (win != window_reg)
            begin
                ovr_next    = 1'b0;
                window_next = win;
            end
            if (ovr_next)
                target = manual_reg;
            else
                target = win ? high_sp_reg : low_sp_reg;
            upper = {{2{target[TEMP_W-1]}}, target} + half;
            lower = {{2{target[TEMP_W-1]}}, target} - half;
            if (temp_ext > upper)
                heater_next = 1'b0;
            else if (temp_ext < lower)
                heater_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heater_reg    <= 1'b0;
            window_reg    <= 1'b0;
            ovr_reg       <= 1'b0;
            manual_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                heater_reg <= heater_next;
                window_reg <= window_next;
                ovr_reg    <= ovr_next;
                manual_reg <= manual_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_heater_reg <= heater_next;
            out_target_reg <= target;
            out_window_reg <= window_next;
            out_ovr_reg    <= ovr_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_ovr_reg, out_window_reg, out_target_reg, out_heater_reg};

`ifndef SYNTH
    // an override beat leaves the heater alone
    a_ovr_keeps_heater: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_op_reg == OP_OVERRIDE |=> heater_reg == $past(heater_reg))
        else $error("override changed heater state");

    // an override beat always reports the override as active with its setpoint
    a_ovr_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_op_reg == OP_OVERRIDE |=> out_ovr_reg && out_target_reg == manual_reg)
        else $error("override result mismatch");

    // the input stage only stalls while it holds a beat
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without cause");

    // reported flags match the state left by the beat
    a_flags_track: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_window_reg == window_reg && out_heater_reg == heater_reg)
        else $error("result flags out of step with state");
`endif

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for scheduled_hysteresis_thermostat
// Drives sample and override beats on the input stream and register writes on
// the APB port. A scoreboard class tracks the thermostat state, predicts the
// status beat for each accepted item and compares it field by field with the
// output stream. Both stream sides idle at random, and one long output stall
// backs the block up against its input.
// ----------------------------------------------------------------------------
import sht_pkg::*;

typedef struct {
    bit    heater;
    temp_t target;
    bit    in_win;
    bit    ovr_active;
} status_t;

class thermostat_scoreboard;
    temp_t   high_sp, low_sp, manual_sp;
    band_t   band;
    tod_t    win_start, win_stop;
    bit      heater, in_win, ovr_active;
    status_t pending_status[$];
    int      mismatches, n_samples, n_overrides, n_window_changes;
    int      n_override_drops, n_heater_turn_on;

    function new();
        high_sp    = RST_HIGH_SETPOINT;
        low_sp     = RST_LOW_SETPOINT;
        band       = RST_HYST_BAND;
        win_start  = RST_WINDOW_START;
        win_stop   = RST_WINDOW_STOP;
        manual_sp  = '0;
        heater     = 1'b0;
        in_win     = 1'b0;
        ovr_active = 1'b0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        case (idx)
            REG_HIGH_SETPOINT: high_sp   = value[TEMP_W-1:0];
            REG_LOW_SETPOINT:  low_sp    = value[TEMP_W-1:0];
            REG_HYST_BAND:     band      = value[BAND_W-1:0];
            REG_WINDOW_START:  win_start = value[TIME_W-1:0];
            REG_WINDOW_STOP:   win_stop  = value[TIME_W-1:0];
            default: ;
        endcase
    endfunction

    // The window wraps past midnight when stop lies below start.
    function bit window_open(tod_t now);
        if (win_stop > win_start)
            return (now > win_start) && (now < win_stop);
        if (win_stop < win_start)
            return (now > win_start) || (now < win_stop);
        return 1'b0;
    endfunction

    function void note_item(logic op, tod_t tod, temp_t temp, temp_t ovr);
        status_t st;
        bit      win;
        bit      was_on;
        int      half;
        temp_t   target;
        was_on = heater;
        if (op == OP_OVERRIDE) begin
            manual_sp  = ovr;
            ovr_active = 1'b1;
            target     = ovr;
            n_overrides++;
        end
        else begin
            win = window_open(tod);
            if (win != in_win) begin
                n_window_changes++;
                if (ovr_active)
                    n_override_drops++;
                ovr_active = 1'b0;
                in_win     = win;
            end
            if (ovr_active)
                target = manual_sp;
            else
                target = win ? high_sp : low_sp;
            half = int'(band >> 1);
            if (int'(temp) > int'(target) + half)
                heater = 1'b0;
            else if (int'(temp) < int'(target) - half)
                heater = 1'b1;
            n_samples++;
        end
        if (heater && !was_on)
            n_heater_turn_on++;
        st.heater     = heater;
        st.target     = target;
        st.in_win     = in_win;
        st.ovr_active = ovr_active;
        pending_status.push_back(st);
    endfunction

    task flag_error(string msg);
        mismatches++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_status(logic [M_DATA_W-1:0] beat);
        status_t want;
        temp_t   got_target;
        if (pending_status.size() == 0) begin
            flag_error($sformatf("status beat 0x%h with nothing pending", beat));
            return;
        end
        want       = pending_status.pop_front();
        got_target = beat[12:1];
        if (beat[0] !== want.heater)
            flag_error($sformatf("heater_on got %0d want %0d", beat[0], want.heater));
        if (got_target !== want.target)
            flag_error($sformatf("target_temperature got %0d want %0d",
                int'(got_target), int'(want.target)));
        if (beat[13] !== want.in_win)
            flag_error($sformatf("in_window got %0d want %0d", beat[13], want.in_win));
        if (beat[14] !== want.ovr_active)
            flag_error($sformatf("override_active got %0d want %0d",
                beat[14], want.ovr_active));
    endtask
endclass

module tb;

    localparam int            QUIET_LIMIT   = 2000;
    localparam int            STALL_CYCLES  = 300;
    localparam int            ITEMS_PER_SET = 147;
    localparam int            NUM_SETTINGS  = 7;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam temp_t         TEMP_MIN      = 12'sh800;
    localparam temp_t         TEMP_MAX      = 12'sh7FF;
    localparam band_t         BAND_MAX      = 10'h3FF;
    localparam tod_t          TOD_MAX       = 17'h1FFFF;
    localparam tod_t          DAY_LAST      = 17'd86399;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = OP_SAMPLE;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    thermostat_scoreboard sb = new();

    int tx_idle_pct   = 31;
    int rx_idle_pct   = 54;
    bit stall_request = 1'b0;
    int quiet_cycles  = 0;

    scheduled_hysteresis_thermostat dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic op, input tod_t tod, input temp_t temp,
                             input temp_t ovr);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, ovr, temp, tod};
        do @(posedge clk); while (!s_tready);
        sb.note_item(op, tod, temp, ovr);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_status.size() != 0)
            @(posedge clk);
        // let the two-stage pipeline settle before touching registers
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(input temp_t hi, input temp_t lo, input band_t band,
                                 input tod_t start, input tod_t stop);
        apb_write(REG_HIGH_SETPOINT, {20'd0, hi});
        apb_write(REG_LOW_SETPOINT, {20'd0, lo});
        apb_write(REG_HYST_BAND, {22'd0, band});
        apb_write(REG_WINDOW_START, {15'd0, start});
        apb_write(REG_WINDOW_STOP, {15'd0, stop});
    endtask

    task automatic configure(input int setting);
        case (setting)
            0: apply_setting(TEMP_MAX, TEMP_MIN, BAND_MAX, 17'd0, TOD_MAX);
            1: apply_setting(TEMP_MIN, TEMP_MAX, 10'd0, DAY_LAST, 17'd0);
            2: apply_setting(12'sd336, 12'sd256, 10'd1, 17'd43200, 17'd43200);
            3: begin
                apb_write(REG_SPARE_LO, $urandom);
                apb_write(REG_SPARE_HI, $urandom);
                apply_setting(-12'sd800, 12'sd2000, 10'd1022, 17'd3600, 17'd7200);
            end
            4: apply_setting(temp_t'($urandom), temp_t'($urandom), band_t'($urandom),
                             tod_t'($urandom_range(TOD_MAX)),
                             tod_t'($urandom_range(TOD_MAX)));
            5: apply_setting(12'sd2000, -12'sd800, 10'd511, TOD_MAX, 17'd100);
            default: apply_setting(RST_HIGH_SETPOINT, RST_LOW_SETPOINT, RST_HYST_BAND,
                                   RST_WINDOW_START, RST_WINDOW_STOP);
        endcase
    endtask

    // Bias times toward the window edges and temperatures toward the
    // hysteresis limits, where the state changes.
    task automatic send_random_item();
        logic  op;
        tod_t  tod;
        temp_t temp, ovr, anchor;
        int    off;
        op  = ($urandom_range(99) < 18) ? OP_OVERRIDE : OP_SAMPLE;
        ovr = temp_t'($urandom_range(4095));
        case ($urandom_range(9))
            0, 1, 2: tod = sb.win_start + tod_t'($urandom_range(6)) - tod_t'(3);
            3, 4, 5: tod = sb.win_stop + tod_t'($urandom_range(6)) - tod_t'(3);
            6: begin
                case ($urandom_range(2))
                    0: tod = '0;
                    1: tod = DAY_LAST;
                    default: tod = TOD_MAX;
                endcase
            end
            default: tod = tod_t'($urandom_range(TOD_MAX));
        endcase
        if ($urandom_range(1) == 0) begin
            temp = temp_t'($urandom_range(4095));
        end
        else begin
            case ($urandom_range(2))
                0: anchor = sb.high_sp;
                1: anchor = sb.low_sp;
                default: anchor = sb.manual_sp;
            endcase
            off = int'(sb.band >> 1) + $urandom_range(4) - 2;
            if ($urandom_range(1) == 0)
                off = -off;
            temp = temp_t'(int'(anchor) + off);
        end
        send_item(op, tod, temp, ovr);
    endtask

    // Output side: check accepted beats, throttle tready, run the long stall.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_status(m_tdata);
            if (stall_request) begin
                hold_left     = STALL_CYCLES;
                stall_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("tb failed");
        $finish;
    end

    initial begin
        int setting;
        int i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hysteresis limits around the low target, window edges,
        // overrides kept inside one window and dropped when it changes
        send_item(OP_SAMPLE, 17'd40000, 12'sd247, 12'sd0);
        send_item(OP_SAMPLE, 17'd40000, 12'sd248, TEMP_MAX);
        send_item(OP_SAMPLE, 17'd40000, 12'sd264, 12'sd0);
        send_item(OP_SAMPLE, 17'd40000, 12'sd265, TEMP_MIN);
        send_item(OP_SAMPLE, RST_WINDOW_START, TEMP_MIN, 12'sd0);
        send_item(OP_SAMPLE, 17'd79201, TEMP_MAX, 12'sd0);
        send_item(OP_OVERRIDE, 17'd0, 12'sd0, TEMP_MAX);
        send_item(OP_SAMPLE, DAY_LAST, 12'sd2000, 12'sd0);
        send_item(OP_SAMPLE, 17'd0, -12'sd800, 12'sd0);
        send_item(OP_SAMPLE, 17'd32399, 12'sd2038, 12'sd0);
        send_item(OP_SAMPLE, RST_WINDOW_STOP, TEMP_MAX, 12'sd0);
        send_item(OP_OVERRIDE, TOD_MAX, TEMP_MAX, TEMP_MIN);
        send_item(OP_SAMPLE, 17'd50000, 12'sd0, 12'sd0);
        send_item(OP_OVERRIDE, 17'd50000, 12'sd0, 12'sd0);
        send_item(OP_SAMPLE, TOD_MAX, 12'sd100, TEMP_MAX);
        send_item(OP_OVERRIDE, TOD_MAX, TEMP_MIN, -12'sd800);
        send_item(OP_OVERRIDE, 17'd1, TEMP_MAX, 12'sd2000);
        send_item(OP_SAMPLE, 17'd50000, TEMP_MAX, 12'sd2000);
        send_item(OP_SAMPLE, 17'd50000, TEMP_MIN, TEMP_MIN);
        drain_results();

        for (setting = 0; setting < NUM_SETTINGS; setting++) begin
            configure(setting);
            if (setting < 2) begin
                tx_idle_pct = 31;
                rx_idle_pct = 54;
            end
            else if (setting < 4) begin
                tx_idle_pct = 54;
                rx_idle_pct = 31;
            end
            else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (i = 0; i < ITEMS_PER_SET; i++) begin
                if (setting == 2 && i == 40)
                    stall_request = 1'b1;
                if (setting == 5 && i == 70)
                    drain_results();
                send_random_item();
            end
            drain_results();
        end

        $display("covered %0d samples and %0d overrides over %0d register settings",
            sb.n_samples, sb.n_overrides, NUM_SETTINGS + 1);
        $display("window changes %0d, overrides dropped %0d, heater turn-ons %0d",
            sb.n_window_changes, sb.n_override_drops, sb.n_heater_turn_on);
        if (sb.mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
